// ===== rtl/core/ptc_pkg.sv =====
`timescale 1ns / 1ps

package ptc_pkg;

  localparam int CFG_W       = 48;
  localparam int CFG_IDX_W   = 2;
  localparam int DEND_W      = 64;
  localparam int DIV_W       = 31;
  localparam int DIV_STEPS   = DEND_W;
  localparam int TEMP_W      = 19;
  localparam int PRE_STAGES  = 11;
  localparam int POST_STAGES = 5;

  localparam logic signed [24:0] FINE_OFFSET = 25'sd128000;
  localparam logic signed [26:0] ROUND_HALF  = 27'sd128;
  localparam logic [20:0]        PRESS_FULL  = 21'd1048576;
  localparam logic [63:0]        P1_BIAS     = 64'h0000_8000_0000_0000;
  localparam logic [63:0]        DEND_SCALE  = 64'd3125;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEMP_CALIB   = 2'd0,
    REG_PRESS_FIRST  = 2'd1,
    REG_PRESS_MIDDLE = 2'd2,
    REG_PRESS_LAST   = 2'd3
  } ptc_reg_t;

  typedef struct packed {
    logic [19:0] raw_temp;
    logic [19:0] raw_press;
  } ptc_in_t;

  typedef struct packed {
    logic signed [31:0] temp_centi;
    logic [31:0]        press_q24_8;
    logic               divisor_zero;
  } ptc_out_t;

  // rides alongside the divider
  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic                     zero;
    logic                     neg;
  } ptc_side_t;

endpackage

// ===== rtl/core/ptc_div.sv =====
`timescale 1ns / 1ps

module ptc_div import ptc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [DEND_W-1:0] dividend,
  input  logic [DIV_W-1:0]  divisor,
  input  ptc_side_t         in_side,
  output logic              out_valid,
  output logic [DEND_W-1:0] quotient,
  output ptc_side_t         out_side
);

  logic [DIV_STEPS-1:0] vld;
  logic [DIV_W-1:0]     rem      [DIV_STEPS];
  logic [DEND_W-1:0]    shq      [DIV_STEPS];
  logic [DIV_W-1:0]     dvs      [DIV_STEPS];
  ptc_side_t            side     [DIV_STEPS];
  logic [DIV_W-1:0]     rem_src  [DIV_STEPS];
  logic [DEND_W-1:0]    shq_src  [DIV_STEPS];
  logic [DIV_W-1:0]     dvs_src  [DIV_STEPS];
  ptc_side_t            side_src [DIV_STEPS];
  logic [DIV_W:0]       trial    [DIV_STEPS];
  logic [DIV_W-1:0]     rem_next [DIV_STEPS];
  logic [DEND_W-1:0]    shq_next [DIV_STEPS];

  always_comb begin
    rem_src[0]  = '0;
    shq_src[0]  = dividend;
    dvs_src[0]  = divisor;
    side_src[0] = in_side;
    for (int k = 1; k < DIV_STEPS; k++) begin
      rem_src[k]  = rem[k-1];
      shq_src[k]  = shq[k-1];
      dvs_src[k]  = dvs[k-1];
      side_src[k] = side[k-1];
    end
    // one restoring step per stage: shift in a dividend bit, shift out a quotient bit
    for (int k = 0; k < DIV_STEPS; k++) begin
      trial[k] = {rem_src[k], shq_src[k][DEND_W-1]};
      if (trial[k] >= {1'b0, dvs_src[k]}) begin
        rem_next[k] = DIV_W'(trial[k] - {1'b0, dvs_src[k]});
        shq_next[k] = {shq_src[k][DEND_W-2:0], 1'b1};
      end else begin
        rem_next[k] = trial[k][DIV_W-1:0];
        shq_next[k] = {shq_src[k][DEND_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DIV_STEPS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_STEPS; k++) begin
        rem[k]  <= rem_next[k];
        shq[k]  <= shq_next[k];
        dvs[k]  <= dvs_src[k];
        side[k] <= side_src[k];
      end
    end
  end

  assign out_valid = vld[DIV_STEPS-1];
  assign quotient  = shq[DIV_STEPS-1];
  assign out_side  = side[DIV_STEPS-1];

endmodule

// ===== rtl/core/pressure_temperature_compensation.sv =====
`timescale 1ns / 1ps

// Compensates one raw temperature / raw pressure pair per clock and returns the
// temperature in 0.01 degree units, the pressure in unsigned Q24.8 pascals and a
// flag that forces pressure to 0 when the calibration gives a zero divisor.
// The path holds 81 registers, the first loaded at the accepting edge: 11 stages
// of calibration arithmetic, 64 stages of the restoring divider (one quotient
// bit per stage, which sets the depth), 5 stages of correction terms and the
// output register. A new request is taken every cycle; in_ready drops only in
// reset and while a finished result waits in the output register, and then the
// whole pipe holds. Write the four calibration words only while no request is
// in flight.
module pressure_temperature_compensation import ptc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ptc_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ptc_out_t             out_data,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [CFG_W-1:0] temp_calib, press_calib_first, press_calib_middle, press_calib_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_calib         <= '0;
      press_calib_first  <= '0;
      press_calib_middle <= '0;
      press_calib_last   <= '0;
    end else if (cfg_write) begin
      unique case (ptc_reg_t'(cfg_index))
        REG_TEMP_CALIB:   temp_calib         <= cfg_data;
        REG_PRESS_FIRST:  press_calib_first  <= cfg_data;
        REG_PRESS_MIDDLE: press_calib_middle <= cfg_data;
        REG_PRESS_LAST:   press_calib_last   <= cfg_data;
      endcase
    end
  end

  logic [15:0]        t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

  assign t1 = temp_calib[15:0];
  assign t2 = $signed(temp_calib[31:16]);
  assign t3 = $signed(temp_calib[47:32]);
  assign p1 = press_calib_first[15:0];
  assign p2 = $signed(press_calib_first[31:16]);
  assign p3 = $signed(press_calib_first[47:32]);
  assign p4 = $signed(press_calib_middle[15:0]);
  assign p5 = $signed(press_calib_middle[31:16]);
  assign p6 = $signed(press_calib_middle[47:32]);
  assign p7 = $signed(press_calib_last[15:0]);
  assign p8 = $signed(press_calib_last[31:16]);
  assign p9 = $signed(press_calib_last[47:32]);

  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv && !rst;

  logic [PRE_STAGES-1:0]  pv;
  logic [POST_STAGES-1:0] qv;
  logic                   d_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      pv        <= '0;
      qv        <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      pv        <= {pv[PRE_STAGES-2:0], in_valid};
      qv        <= {qv[POST_STAGES-2:0], d_valid};
      out_valid <= qv[POST_STAGES-1];
    end
  end

  // temperature stages
  logic signed [17:0]       s1_d1;
  logic signed [16:0]       s1_d2;
  logic [19:0]              s1_ap, s2_ap, s3_ap, s4_ap, s5_ap, s6_ap, s7_ap;
  logic signed [33:0]       s2_m1;
  logic [31:0]              s2_sq;
  logic signed [22:0]       s3_ta;
  logic signed [36:0]       s3_tb;
  logic signed [23:0]       s4_fine;
  logic signed [TEMP_W-1:0] s5_temp, s6_temp, s7_temp, s8_temp, s9_temp, s10_temp;
  logic signed [24:0]       s5_pa;
  // pressure stages
  logic signed [49:0]       s6_aa;
  logic signed [40:0]       s6_ap5, s6_ap2, s7_ap5, s7_ap2;
  logic signed [63:0]       s7_bb, s7_ab3, s8_b, s8_asum;
  logic [20:0]              s8_x;
  logic [63:0]              s9_pa47, s9_num, s10_dnd, s11_ua;
  logic signed [DIV_W-1:0]  s10_dv;
  logic [DIV_W-1:0]         s11_ub;
  ptc_side_t                s11_side;

  logic signed [33:0] d2sq;
  logic signed [26:0] f4, f1, tr;
  logic signed [65:0] bbx, ab3x;
  logic signed [63:0] ap5w, ap2w, p4w;
  logic [79:0]        dvx;

  always_comb begin
    d2sq = s1_d2 * s1_d2;
    f4   = {s4_fine[23], s4_fine, 2'b00};
    f1   = 27'(s4_fine);
    tr   = f4 + f1 + ROUND_HALF;
    bbx  = s6_aa * p6;
    ab3x = s6_aa * p3;
    ap5w = 64'(s7_ap5);
    ap2w = 64'(s7_ap2);
    p4w  = 64'(p4);
    dvx  = s9_pa47 * p1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_d1    <= $signed({1'b0, in_data.raw_temp[19:3]}) - $signed({1'b0, t1, 1'b0});
      s1_d2    <= $signed({1'b0, in_data.raw_temp[19:4]}) - $signed({1'b0, t1});
      s1_ap    <= in_data.raw_press;

      s2_m1    <= s1_d1 * t2;
      s2_sq    <= d2sq[31:0];
      s2_ap    <= s1_ap;

      s3_ta    <= s2_m1[33:11];
      s3_tb    <= $signed({1'b0, s2_sq[31:12]}) * t3;
      s3_ap    <= s2_ap;

      s4_fine  <= s3_ta + $signed(s3_tb[36:14]);
      s4_ap    <= s3_ap;

      s5_temp  <= tr[26 -: TEMP_W];
      s5_pa    <= 25'(s4_fine) - FINE_OFFSET;
      s5_ap    <= s4_ap;

      s6_aa    <= s5_pa * s5_pa;
      s6_ap5   <= s5_pa * p5;
      s6_ap2   <= s5_pa * p2;
      s6_temp  <= s5_temp;
      s6_ap    <= s5_ap;

      s7_bb    <= bbx[63:0];
      s7_ab3   <= ab3x[63:0];
      s7_ap5   <= s6_ap5;
      s7_ap2   <= s6_ap2;
      s7_temp  <= s6_temp;
      s7_ap    <= s6_ap;

      s8_b     <= s7_bb + (ap5w <<< 17) + (p4w <<< 35);
      s8_asum  <= (s7_ab3 >>> 8) + (ap2w <<< 12);
      s8_x     <= PRESS_FULL - {1'b0, s7_ap};
      s8_temp  <= s7_temp;

      s9_pa47  <= s8_asum + P1_BIAS;
      s9_num   <= {12'b0, s8_x, 31'b0} - s8_b;
      s9_temp  <= s8_temp;

      s10_dv   <= dvx[63:33];
      s10_dnd  <= s9_num * DEND_SCALE;
      s10_temp <= s9_temp;

      // split into magnitudes; the divider works unsigned
      s11_ua        <= s10_dnd[63] ? (~s10_dnd + 64'd1) : s10_dnd;
      s11_ub        <= s10_dv[DIV_W-1] ? (~s10_dv + 1'b1) : s10_dv;
      s11_side.temp <= s10_temp;
      s11_side.zero <= (s10_dv == '0);
      s11_side.neg  <= s10_dnd[63] ^ s10_dv[DIV_W-1];
    end
  end

  logic [DEND_W-1:0] d_q;
  ptc_side_t         d_side;

  ptc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (pv[PRE_STAGES-1]),
    .dividend  (s11_ua),
    .divisor   (s11_ub),
    .in_side   (s11_side),
    .out_valid (d_valid),
    .quotient  (d_q),
    .out_side  (d_side)
  );

  // correction stages
  logic signed [63:0]       pa_p, pb_p, pc_p, pd_p;
  logic signed [TEMP_W-1:0] pa_temp, pb_temp, pc_temp, pd_temp, pe_temp;
  logic                     pa_zero, pb_zero, pc_zero, pd_zero, pe_zero;
  logic [63:0]              pb_ll, pc_sq;
  logic [30:0]              pb_cross;
  logic signed [63:0]       pb_w2, pc_w2, pd_w2, pd_w1, pe_s;

  logic signed [63:0] ps;
  logic [31:0]        crs;
  logic signed [79:0] w2x, w1x;
  logic [31:0]        press32;

  always_comb begin
    ps      = pa_p >>> 13;
    crs     = ps[63:32] * ps[31:0];
    w2x     = pa_p * p8;
    w1x     = $signed(pc_sq) * p9;
    press32 = pe_s[39:8] + {{12{p7[15]}}, p7, 4'b0000};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pa_p     <= d_side.neg ? $signed(~d_q + 64'd1) : $signed(d_q);
      pa_temp  <= d_side.temp;
      pa_zero  <= d_side.zero;

      // square of the shifted quotient, low 64 bits from 32-bit halves
      pb_ll    <= ps[31:0] * ps[31:0];
      pb_cross <= crs[30:0];
      pb_w2    <= w2x[63:0];
      pb_p     <= pa_p;
      pb_temp  <= pa_temp;
      pb_zero  <= pa_zero;

      pc_sq    <= pb_ll + {pb_cross, 33'b0};
      pc_w2    <= pb_w2;
      pc_p     <= pb_p;
      pc_temp  <= pb_temp;
      pc_zero  <= pb_zero;

      pd_w1    <= w1x[63:0];
      pd_w2    <= pc_w2;
      pd_p     <= pc_p;
      pd_temp  <= pc_temp;
      pd_zero  <= pc_zero;

      pe_s     <= pd_p + (pd_w1 >>> 25) + (pd_w2 >>> 19);
      pe_temp  <= pd_temp;
      pe_zero  <= pd_zero;

      out_data.temp_centi   <= 32'(pe_temp);
      out_data.press_q24_8  <= pe_zero ? 32'd0 : press32;
      out_data.divisor_zero <= pe_zero;
    end
  end

`ifndef NO_ASSERTIONS
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output result is stalled");

  a_enter_pipe: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> pv[0])
    else $error("accepted request missing from first stage");

  a_zero_press: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.divisor_zero |-> out_data.press_q24_8 == 32'd0)
    else $error("zero divisor with nonzero pressure");
`endif

endmodule

// ===== sim/tb_pressure_temperature_compensation.sv =====
`timescale 1ns / 1ps

module tb_pressure_temperature_compensation;
  import ptc_pkg::*;

  typedef logic [63:0] u64_t;

  // Calibration copy and prediction for the compensation formulas.
  class compensation_board;
    logic [47:0] calib [4];
    ptc_out_t    pending [$];
    int          mismatches;

    function new();
      for (int i = 0; i < 4; i++) calib[i] = '0;
      mismatches = 0;
    endfunction

    function u64_t wu(int r, int k);
      return u64_t'(calib[r][16*k +: 16]);
    endfunction

    function u64_t ws(int r, int k);
      logic signed [15:0] w;
      w = calib[r][16*k +: 16];
      return u64_t'(64'(w));
    endfunction

    function u64_t shr(u64_t x, int n);
      return u64_t'($signed(x) >>> n);
    endfunction

    function u64_t quot(u64_t a, u64_t b);
      u64_t ua, ub, q;
      ua = a[63] ? -a : a;
      ub = b[63] ? -b : b;
      q = ua / ub;
      return (a[63] != b[63]) ? -q : q;
    endfunction

    function void note_request(ptc_in_t req);
      u64_t at, ap, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      u64_t d, a, b, fine, temp, p, ps, w1, w2;
      ptc_out_t res;
      at = u64_t'(req.raw_temp);
      ap = u64_t'(req.raw_press);
      t1 = wu(0, 0); t2 = ws(0, 1); t3 = ws(0, 2);
      p1 = wu(1, 0); p2 = ws(1, 1); p3 = ws(1, 2);
      p4 = ws(2, 0); p5 = ws(2, 1); p6 = ws(2, 2);
      p7 = ws(3, 0); p8 = ws(3, 1); p9 = ws(3, 2);
      d = (at >> 3) - (t1 << 1);
      a = shr(d * t2, 11);
      d = (at >> 4) - t1;
      b = shr(shr(d * d, 12) * t3, 14);
      fine = a + b;
      temp = shr(fine * 5 + 128, 8);
      a = fine - 128000;
      b = a * a * p6;
      b = b + ((a * p5) << 17);
      b = b + (p4 << 35);
      a = shr(a * a * p3, 8) + ((a * p2) << 12);
      a = shr(((64'd1 << 47) + a) * p1, 33);
      res.temp_centi = temp[31:0];
      if (a == 0) begin
        res.press_q24_8 = '0;
        res.divisor_zero = 1'b1;
      end else begin
        p = 64'd1048576 - ap;
        p = quot(((p << 31) - b) * 3125, a);
        ps = shr(p, 13);
        w1 = shr(p9 * ps * ps, 25);
        w2 = shr(p8 * p, 19);
        p = shr(p + w1 + w2, 8) + (p7 << 4);
        res.press_q24_8 = p[31:0];
        res.divisor_zero = 1'b0;
      end
      pending.push_back(res);
    endfunction

    function void check_result(ptc_out_t got);
      ptc_out_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      if (got.temp_centi !== want.temp_centi || got.press_q24_8 !== want.press_q24_8 ||
          got.divisor_zero !== want.divisor_zero) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected t=%0d p=%h z=%b, got t=%0d p=%h z=%b",
                   want.temp_centi, want.press_q24_8, want.divisor_zero,
                   got.temp_centi, got.press_q24_8, got.divisor_zero);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  ptc_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  ptc_out_t out_data;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_TEMP_CALIB;
  logic [CFG_W-1:0] cfg_data = '0;

  compensation_board board = new();
  int send_idle = 0;
  int recv_idle = 0;
  int hold_off = 0;
  int unsigned cycles = 0;
  localparam int unsigned CYCLE_LIMIT = 2000000;

  always #4 clk = ~clk;

  pressure_temperature_compensation dut (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk)
    if (!rst && out_valid && out_ready) board.check_result(out_data);

  // receiver side: random stalls plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic write_reg(ptc_reg_t idx, logic [47:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    board.calib[idx] = val;
  endtask

  // valid stays up past the accepting edge; the next negedge drops or replaces it
  task automatic send_request(logic [19:0] rt, logic [19:0] rp);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{raw_temp: rt, raw_press: rp};
    do @(posedge clk); while (!in_ready);
    board.note_request(in_data);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  function automatic logic [15:0] rword(int mode);
    case (mode)
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Typical sensor-like calibration with random perturbation.
  task automatic load_typical();
    write_reg(REG_TEMP_CALIB, {16'($urandom_range(100)) - 16'd50,
                               16'(26000 + $urandom_range(1000)),
                               16'(27000 + $urandom_range(2000))});
    write_reg(REG_PRESS_FIRST, {16'hF000 + 16'($urandom_range(400)),
                                16'hD500 + 16'($urandom_range(400)),
                                16'(35000 + $urandom_range(2000))});
    write_reg(REG_PRESS_MIDDLE, {16'hFFF0 + 16'($urandom_range(15)),
                                 16'($urandom_range(200)),
                                 16'(2500 + $urandom_range(1000))});
    write_reg(REG_PRESS_LAST, {16'(5000 + $urandom_range(2000)),
                               16'hC000 + 16'($urandom_range(400)),
                               16'($urandom_range(50))});
  endtask

  task automatic load_extreme();
    for (int r = 0; r < 4; r++)
      write_reg(ptc_reg_t'(r), {rword($urandom_range(5)), rword($urandom_range(5)),
                                rword($urandom_range(5))});
  endtask

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) begin
        drain();
        if ($urandom_range(3) == 0) load_extreme(); else load_typical();
      end
      if ($urandom_range(9) < 7)
        send_request(20'(400000 + $urandom_range(300000)),
                     20'(250000 + $urandom_range(400000)));
      else
        send_request(20'($urandom), 20'($urandom));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // all-zero calibration: divisor zero
    send_request(20'h00000, 20'h00000);
    send_request(20'hFFFFF, 20'hFFFFF);
    drain();
    load_typical();
    send_request(20'h00000, 20'h00000);
    send_request(20'hFFFFF, 20'hFFFFF);
    send_request(20'h80000, 20'h7FFFF);
    send_request(20'd519888, 20'd415148);
    drain();
    // most extreme words everywhere
    for (int m = 1; m < 4; m++) begin
      for (int r = 0; r < 4; r++)
        write_reg(ptc_reg_t'(r), {rword(m), rword(m), rword(m)});
      send_request(20'h00000, 20'hFFFFF);
      send_request(20'hFFFFF, 20'h00000);
      send_request(20'h55555, 20'hAAAAA);
      drain();
    end
    // P1 zero with others nonzero: flag with valid temperature
    load_typical();
    write_reg(REG_PRESS_FIRST, 48'h1234_5678_0000);
    send_request(20'd519888, 20'd415148);
    drain();
    load_typical();
    // let the pipe fill and stall the input
    hold_off = 400;
    for (int i = 0; i < 150; i++) send_request(20'($urandom), 20'($urandom));
    drain();

    send_idle = 16; recv_idle = 45;
    random_phase(560);
    send_idle = 45; recv_idle = 16;
    random_phase(560);
    send_idle = 0; recv_idle = 0;
    random_phase(560);
    drain();

    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/core/ptc_pkg.sv
rtl/core/ptc_div.sv
rtl/core/pressure_temperature_compensation.sv
sim/tb_pressure_temperature_compensation.sv
